FILE: hw/rtl/fdltp_pkg.sv
// ----------------------------------------------------------------------------
// fdltp_pkg
// Shared types and constants of the fieldbus telegram parser.
// ----------------------------------------------------------------------------
package fdltp_pkg;

  // width of the saturating octet position counter, at least 9
  localparam int unsigned PosBits = 9;

  localparam int unsigned OctetBits   = 8;
  localparam int unsigned OutDataBits = 48;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrBits = $clog2(FifoDepth);
  localparam int unsigned FifoCntBits = $clog2(FifoDepth + 1);

  // frame layout offsets
  localparam logic [PosBits-1:0] Sd1BodyEnd = PosBits'(6 - 2);
  localparam logic [PosBits-1:0] Sd3BodyEnd = PosBits'(14 - 2);
  localparam logic [PosBits-1:0] HdrBase    = PosBits'(1);
  localparam logic [PosBits-1:0] Sd2Base    = PosBits'(4);
  localparam logic [7:0]         MinLength  = 8'd4;
  localparam logic [7:0]         Sd3DataLen = 8'd8;
  localparam logic [7:0]         LenOffset  = 8'd3;

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  localparam logic [7:0] Sd1Reset = 8'd16;
  localparam logic [7:0] Sd2Reset = 8'd104;
  localparam logic [7:0] Sd3Reset = 8'd162;
  localparam logic [7:0] EndReset = 8'd22;

  typedef enum logic [1:0] {
    CFG_SD1 = 2'd0,
    CFG_SD2 = 2'd1,
    CFG_SD3 = 2'd2,
    CFG_END = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SD1  = 2'd1,
    KIND_SD2  = 2'd2,
    KIND_SD3  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FT_NO_DATA  = 2'd0,
    FT_VARIABLE = 2'd1,
    FT_FIXED8   = 2'd2,
    FT_UNUSED   = 2'd3
  } frame_type_e;

  typedef enum logic {
    ITEM_PAYLOAD = 1'b0,
    ITEM_VERDICT = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [7:0]  sd1;
    logic [7:0]  sd2;
    logic [7:0]  sd3;
    logic [7:0]  end_code;
  } codes_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic        ok;
    logic [1:0]  frame_type;
    logic [7:0]  dest_address;
    logic [7:0]  src_address;
    logic [7:0]  function_code;
    logic [7:0]  data_length;
    logic        last_of_run;
  } result_t;

  // up to two results per octet, first slot delivered first
  typedef struct packed {
    logic [1:0]  count;
    result_t     first;
    result_t     second;
  } push_t;

endpackage

FILE: hw/rtl/fdltp_parser.sv
// ----------------------------------------------------------------------------
// fdltp_parser
// Per-octet telegram state, delimiter registers and result formation.
// ----------------------------------------------------------------------------
module fdltp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                take_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                buffer_end_i,
  output fdltp_pkg::push_t    push_o
);
  import fdltp_pkg::*;

  codes_t              codes_q;
  logic [PosBits-1:0]  pos_q, pos_d;
  kind_e               kind_q, kind_d;
  logic [7:0]          le_q, le_d;
  logic [7:0]          chk_q, chk_d;
  logic [7:0]          dest_q, dest_d, src_q, src_d, func_q, func_d;
  logic                bad_q, bad_d, done_q, done_d;
  logic                fwd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= '{sd1: Sd1Reset, sd2: Sd2Reset, sd3: Sd3Reset, end_code: EndReset};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_SD1: codes_q.sd1      <= cfg_wdata_i;
        CFG_SD2: codes_q.sd2      <= cfg_wdata_i;
        CFG_SD3: codes_q.sd3      <= cfg_wdata_i;
        CFG_END: codes_q.end_code <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [PosBits-1:0] base;
    logic [PosBits-1:0] body_end;
    logic [PosBits-1:0] idx;
    logic               known;
    kind_d   = kind_q;
    le_d     = le_q;
    chk_d    = chk_q;
    dest_d   = dest_q;
    src_d    = src_q;
    func_d   = func_q;
    bad_d    = bad_q;
    done_d   = done_q;
    fwd      = 1'b0;
    base     = HdrBase;
    body_end = Sd1BodyEnd;
    known    = 1'b1;
    case (kind_q)
      KIND_SD2: begin
        base     = Sd2Base;
        body_end = Sd2Base + PosBits'(le_q);
      end
      KIND_SD3: body_end = Sd3BodyEnd;
      KIND_SD1: body_end = Sd1BodyEnd;
      default:  known = 1'b0;
    endcase
    idx = pos_q - base;

    if (!(bad_q || done_q)) begin
      if (pos_q == '0) begin
        if (rx_byte_i == codes_q.sd3)      kind_d = KIND_SD3;
        else if (rx_byte_i == codes_q.sd1) kind_d = KIND_SD1;
        else if (rx_byte_i == codes_q.sd2) kind_d = KIND_SD2;
        else                               bad_d  = 1'b1;
      end else if (kind_q == KIND_SD2 && pos_q == PosBits'(1)) begin
        le_d = rx_byte_i;
      end else if (kind_q == KIND_SD2 && pos_q == PosBits'(2)) begin
        if (rx_byte_i != le_q) bad_d = 1'b1;
      end else if (kind_q == KIND_SD2 && pos_q == PosBits'(3)) begin
        if (rx_byte_i != codes_q.sd2 || le_q < MinLength) bad_d = 1'b1;
      end else if (!known) begin
        bad_d = 1'b1;
      end else if (pos_q < body_end) begin
        chk_d = chk_q + rx_byte_i;
        if (idx == PosBits'(0))      dest_d = rx_byte_i;
        else if (idx == PosBits'(1)) src_d  = rx_byte_i;
        else if (idx == PosBits'(2)) func_d = rx_byte_i;
        else                         fwd    = 1'b1;
      end else if (pos_q == body_end) begin
        if (rx_byte_i != chk_q) bad_d = 1'b1;
      end else begin
        if (rx_byte_i != codes_q.end_code) bad_d = 1'b1;
        done_d = 1'b1;
      end
    end
    pos_d = (pos_q == PosMax) ? pos_q : pos_q + PosBits'(1);
  end

  // result formation from the updated frame state
  always_comb begin
    result_t pay;
    result_t ver;
    logic    ok;
    pay              = '0;
    pay.item_kind    = ITEM_PAYLOAD;
    pay.payload_byte = rx_byte_i;
    pay.last_of_run  = !buffer_end_i;

    ok              = done_d && !bad_d;
    ver             = '0;
    ver.item_kind   = ITEM_VERDICT;
    ver.last_of_run = 1'b1;
    if (ok) begin
      ver.ok            = 1'b1;
      ver.dest_address  = dest_d;
      ver.src_address   = src_d;
      ver.function_code = func_d;
      case (kind_d)
        KIND_SD2: begin
          ver.frame_type  = FT_VARIABLE;
          ver.data_length = le_d - LenOffset;
        end
        KIND_SD3: begin
          ver.frame_type  = FT_FIXED8;
          ver.data_length = Sd3DataLen;
        end
        default: begin
          ver.frame_type  = FT_NO_DATA;
          ver.data_length = '0;
        end
      endcase
    end

    push_o.count  = take_i ? ({1'b0, fwd} + {1'b0, buffer_end_i}) : 2'd0;
    push_o.first  = fwd ? pay : ver;
    push_o.second = ver;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kind_q <= KIND_NONE;
      le_q   <= '0;
      chk_q  <= '0;
      dest_q <= '0;
      src_q  <= '0;
      func_q <= '0;
      bad_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (take_i) begin
      if (buffer_end_i) begin
        // buffer closed, start over for the next one
        pos_q  <= '0;
        kind_q <= KIND_NONE;
        le_q   <= '0;
        chk_q  <= '0;
        dest_q <= '0;
        src_q  <= '0;
        func_q <= '0;
        bad_q  <= 1'b0;
        done_q <= 1'b0;
      end else begin
        pos_q  <= pos_d;
        kind_q <= kind_d;
        le_q   <= le_d;
        chk_q  <= chk_d;
        dest_q <= dest_d;
        src_q  <= src_d;
        func_q <= func_d;
        bad_q  <= bad_d;
        done_q <= done_d;
      end
    end
  end

endmodule

FILE: hw/rtl/fdltp_result_fifo.sv
// ----------------------------------------------------------------------------
// fdltp_result_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module fdltp_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fdltp_pkg::push_t    push_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output fdltp_pkg::result_t  head_o
);
  import fdltp_pkg::*;

  result_t                 mem_q [FifoDepth];
  logic [FifoPtrBits-1:0]  wptr_q, rptr_q;
  logic [FifoCntBits-1:0]  cnt_q, cnt_d;
  logic                    pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  // room for a full pair regardless of the consumer
  assign room_o  = (cnt_q <= FifoCntBits'(FifoDepth - 2));
  assign head_o  = mem_q[rptr_q];
  assign cnt_d   = cnt_q + FifoCntBits'(push_i.count) - FifoCntBits'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_q + FifoPtrBits'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + FifoPtrBits'(push_i.count);
      if (pop) begin
        rptr_q <= rptr_q + FifoPtrBits'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/fdl_telegram_parser_core.sv
// ----------------------------------------------------------------------------
// fdl_telegram_parser_core
// Fieldbus data link telegram parser: classifies, checks and unpacks frames.
// ----------------------------------------------------------------------------
// a result is written into the queue on its octet transfer
// throughput: one octet per cycle while the queue has room; an octet that
//   yields a payload result and a verdict queues both for one-wide output
// a four-entry result queue decouples input from output stalls
// reset: asynchronous, clears frame state and queue, delimiters to defaults
module fdl_telegram_parser_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  input  logic         s_axis_tlast,   // buffer_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] payload_byte, [8] ok, [10:9] frame_type, [18:11] dest_address,
  // [26:19] src_address, [34:27] function_code, [42:35] data_length, rest zero
  output logic [fdltp_pkg::OutDataBits-1:0] m_axis_tdata,
  output logic         m_axis_tuser,   // item_kind
  output logic         m_axis_tlast    // last_of_run
);
  import fdltp_pkg::*;

  logic     room;
  logic     take;
  push_t    push;
  result_t  head;

  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && room;

  fdltp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .take_i       (take),
    .rx_byte_i    (s_axis_tdata),
    .buffer_end_i (s_axis_tlast),
    .push_o       (push)
  );

  fdltp_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {5'd0, head.data_length, head.function_code, head.src_address,
                         head.dest_address, head.frame_type, head.ok, head.payload_byte};
  assign m_axis_tuser = head.item_kind;
  assign m_axis_tlast = head.last_of_run;

endmodule

FILE: tb/tb_fdl_telegram_parser_core.sv
// ----------------------------------------------------------------------------
// tb_fdl_telegram_parser_core
// Self-checking bench for the telegram parser: a short directed table, then
// random buffers (mostly well-formed telegrams, some corrupted, cut short,
// padded or pure noise) under several delimiter settings and stall patterns.
// Every result transfer is checked against typed rows or the parser model.
// ----------------------------------------------------------------------------
module tb_fdl_telegram_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fdltp_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned PhaseItems  = 220;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned LongTail    = 260;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    logic       typed;   // expected verdict written out in the row
    logic       ok;
    logic [1:0] ftype;
    logic [7:0] da;
    logic [7:0] sa;
    logic [7:0] fc;
    logic [7:0] len;
  } dir_row_t;

  // default delimiters: sd1 10, sd2 68, sd3 a2, end 16
  localparam dir_row_t DirRows [21] = '{
    // one-octet buffer, too short
    '{8'h10, 1'b1, 1'b1, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    // unknown start octet
    '{8'hFF, 1'b1, 1'b1, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    // good no-data telegram
    '{8'h10, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h80, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7F, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h16, 1'b1, 1'b1, 1'b1, FT_NO_DATA, 8'hFF, 8'h00, 8'h80, 8'h00},
    // good variable-length telegram, one data octet
    '{8'h68, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h04, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h04, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h68, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h02, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hA5, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hAB, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h16, 1'b1, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    // repeated length differs from length
    '{8'h68, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h05, 1'b0, 1'b0, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h06, 1'b1, 1'b1, 1'b0, FT_NO_DATA, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_addr_i    = CFG_SD1;
  logic [7:0]  cfg_wdata_i   = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  fdl_telegram_parser_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  int unsigned tx_idle_pct = 25;
  int unsigned rx_idle_pct = 88;
  int unsigned error_count = 0;

  result_t     telegram_results_q [$];
  logic [7:0]  buffer_q [$];

  // parser model state
  logic [7:0]         code_sd1 = Sd1Reset;
  logic [7:0]         code_sd2 = Sd2Reset;
  logic [7:0]         code_sd3 = Sd3Reset;
  logic [7:0]         code_end = EndReset;
  logic [PosBits-1:0] octet_pos = '0;
  kind_e              kind_q    = KIND_NONE;
  logic [7:0]         le_q      = '0;
  logic [7:0]         fcs_q     = '0;
  logic [7:0]         da_q      = '0;
  logic [7:0]         sa_q      = '0;
  logic [7:0]         fc_q      = '0;
  logic               bad_q     = 1'b0;
  logic               done_q    = 1'b0;

  // advances the model by one octet, returns the number of results it causes
  function automatic int unsigned parse_octet(input logic [7:0] b, input logic last,
                                              output result_t r_first,
                                              output result_t r_second);
    int      p;
    int      base;
    int      blen;
    int      idx;
    logic    fwd;
    result_t verdict;
    int unsigned n;
    p        = int'(octet_pos);
    fwd      = 1'b0;
    n        = 0;
    r_first  = '0;
    r_second = '0;
    if (!bad_q && !done_q) begin
      if (p == 0) begin
        if (b == code_sd3) kind_q = KIND_SD3;
        else if (b == code_sd1) kind_q = KIND_SD1;
        else if (b == code_sd2) kind_q = KIND_SD2;
        else bad_q = 1'b1;
      end else if (kind_q == KIND_SD2 && p <= 3) begin
        case (p)
          1: le_q = b;
          2: if (b != le_q) bad_q = 1'b1;
          default: if (b != code_sd2 || le_q < MinLength) bad_q = 1'b1;
        endcase
      end else if (kind_q == KIND_NONE) begin
        bad_q = 1'b1;
      end else begin
        case (kind_q)
          KIND_SD2: begin base = 4; blen = int'(le_q); end
          KIND_SD3: begin base = 1; blen = 11; end
          default:  begin base = 1; blen = 3; end
        endcase
        if (p < base + blen) begin
          idx   = p - base;
          fcs_q = fcs_q + b;
          case (idx)
            0: da_q = b;
            1: sa_q = b;
            2: fc_q = b;
            default: fwd = 1'b1;
          endcase
        end else if (p == base + blen) begin
          if (b != fcs_q) bad_q = 1'b1;
        end else begin
          if (b != code_end) bad_q = 1'b1;
          done_q = 1'b1;
        end
      end
    end
    if (octet_pos != PosMax) octet_pos = octet_pos + 1'b1;

    if (fwd) begin
      r_first.item_kind    = ITEM_PAYLOAD;
      r_first.payload_byte = b;
      r_first.last_of_run  = !last;
      n = 1;
    end
    if (last) begin
      verdict = '0;
      verdict.item_kind   = ITEM_VERDICT;
      verdict.last_of_run = 1'b1;
      if (done_q && !bad_q) begin
        verdict.ok            = 1'b1;
        verdict.dest_address  = da_q;
        verdict.src_address   = sa_q;
        verdict.function_code = fc_q;
        case (kind_q)
          KIND_SD2: begin
            verdict.frame_type  = FT_VARIABLE;
            verdict.data_length = le_q - LenOffset;
          end
          KIND_SD3: begin
            verdict.frame_type  = FT_FIXED8;
            verdict.data_length = Sd3DataLen;
          end
          default: verdict.frame_type = FT_NO_DATA;
        endcase
      end
      if (n == 0) r_first = verdict;
      else r_second = verdict;
      n++;
      octet_pos = '0;
      kind_q    = KIND_NONE;
      le_q      = '0;
      fcs_q     = '0;
      da_q      = '0;
      sa_q      = '0;
      fc_q      = '0;
      bad_q     = 1'b0;
      done_q    = 1'b0;
    end
    return n;
  endfunction

  // one buffer into buffer_q: mostly telegrams with random content
  function automatic void build_buffer(input int unsigned tail);
    int unsigned sel;
    int unsigned le;
    int unsigned ndata;
    int unsigned cut;
    frame_type_e ftype;
    logic [7:0]  b;
    logic [7:0]  sum;
    buffer_q.delete();
    sel = $urandom_range(99);
    if (sel < 8 && tail == 0) begin
      repeat ($urandom_range(1, 12)) buffer_q.push_back(8'($urandom_range(255)));
    end else begin
      ftype = frame_type_e'($urandom_range(2));
      le    = 0;
      sel   = $urandom_range(99);
      if (sel < 8) le = $urandom_range(3);
      else if (sel < 18) le = $urandom_range(4, 255);
      else le = $urandom_range(4, 16);
      if (tail != 0) begin
        ftype = FT_VARIABLE;
        le    = 255;
      end
      case (ftype)
        FT_VARIABLE: begin
          buffer_q.push_back(code_sd2);
          buffer_q.push_back(8'(le));
          buffer_q.push_back(8'(le));
          buffer_q.push_back(code_sd2);
        end
        FT_FIXED8: buffer_q.push_back(code_sd3);
        default:   buffer_q.push_back(code_sd1);
      endcase
      if (ftype == FT_VARIABLE && le < 4) begin
        // length too small: whatever follows is ignored
        repeat ($urandom_range(6)) buffer_q.push_back(8'($urandom_range(255)));
      end else begin
        // the length octet counts the addresses, the function code and the data
        case (ftype)
          FT_VARIABLE: ndata = le;
          FT_FIXED8:   ndata = 11;
          default:     ndata = 3;
        endcase
        sum = '0;
        repeat (ndata) begin
          b   = 8'($urandom_range(255));
          sum = sum + b;
          buffer_q.push_back(b);
        end
        buffer_q.push_back(sum);
        buffer_q.push_back(code_end);
      end
      if (tail == 0) begin
        sel = $urandom_range(99);
        if (sel < 12) begin
          buffer_q[$urandom_range(buffer_q.size() - 1)] = 8'($urandom_range(255));
        end else if (sel < 22 && buffer_q.size() > 1) begin
          cut = $urandom_range(1, buffer_q.size() - 1);
          while (buffer_q.size() > cut) void'(buffer_q.pop_back());
        end else if (sel < 37) begin
          repeat ($urandom_range(1, 4)) buffer_q.push_back(8'($urandom_range(255)));
        end
      end
      repeat (tail) buffer_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic send_octet(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // hold the sender until every awaited result has been seen
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (telegram_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (telegram_results_q.size() == 0) begin
        $error("result transfer with nothing awaited: tdata %0h", m_axis_tdata);
        error_count++;
      end else begin
        want = telegram_results_q.pop_front();
        check_field("item_kind", want.item_kind, m_axis_tuser);
        check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
        check_field("ok", want.ok, m_axis_tdata[8]);
        check_field("frame_type", want.frame_type, m_axis_tdata[10:9]);
        check_field("dest_address", want.dest_address, m_axis_tdata[18:11]);
        check_field("src_address", want.src_address, m_axis_tdata[26:19]);
        check_field("function_code", want.function_code, m_axis_tdata[34:27]);
        check_field("data_length", want.data_length, m_axis_tdata[42:35]);
        check_field("tdata_pad", 0, m_axis_tdata[47:43]);
        check_field("last_of_run", want.last_of_run, m_axis_tlast);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin : stall_watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $error("no transfer for %0d cycles", StallLimit);
    $display("** fdl_telegram_parser_core: FAILED **");
    $finish;
  end

  initial begin : main_seq
    int unsigned n;
    int unsigned items_sent;
    bit          long_done;
    result_t     r0;
    result_t     r1;
    result_t     typed;
    logic [7:0]  new_codes [4];
    long_done = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) begin
      send_octet(DirRows[i].octet, DirRows[i].last);
      n = parse_octet(DirRows[i].octet, DirRows[i].last, r0, r1);
      if (DirRows[i].typed) begin
        typed               = '0;
        typed.item_kind     = ITEM_VERDICT;
        typed.ok            = DirRows[i].ok;
        typed.frame_type    = DirRows[i].ftype;
        typed.dest_address  = DirRows[i].da;
        typed.src_address   = DirRows[i].sa;
        typed.function_code = DirRows[i].fc;
        typed.data_length   = DirRows[i].len;
        typed.last_of_run   = 1'b1;
        telegram_results_q.push_back(typed);
      end else begin
        if (n > 0) telegram_results_q.push_back(r0);
        if (n > 1) telegram_results_q.push_back(r1);
      end
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      case (phase)
        0, 1: begin tx_idle_pct = 25; rx_idle_pct = 88; end
        2, 3: begin tx_idle_pct = 88; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case (phase)
        0: new_codes = '{Sd1Reset, Sd2Reset, Sd3Reset, EndReset};
        1: new_codes = '{8'h00, 8'hFF, 8'h80, 8'h00};
        2: new_codes = '{8'hFF, 8'h00, 8'h01, 8'hFF};
        // all delimiters equal: the fixed-data telegram wins
        3: new_codes = '{8'h5A, 8'h5A, 8'h5A, 8'h5A};
        4: new_codes = '{8'h21, 8'h21, 8'h7E, 8'($urandom_range(255))};
        default: new_codes = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255))};
      endcase
      for (int i = 0; i < 4; i++) begin
        cfg_we_i    <= 1'b1;
        cfg_addr_i  <= cfg_idx_e'(i);
        cfg_wdata_i <= new_codes[i];
        @(posedge clk_i);
        case (cfg_idx_e'(i))
          CFG_SD1: code_sd1 = new_codes[i];
          CFG_SD2: code_sd2 = new_codes[i];
          CFG_SD3: code_sd3 = new_codes[i];
          default: code_end = new_codes[i];
        endcase
      end
      cfg_we_i <= 1'b0;
      @(posedge clk_i);

      items_sent = 0;
      while (items_sent < PhaseItems) begin
        // one buffer long enough to saturate the position counter
        if (phase == NumPhases - 1 && !long_done) begin
          build_buffer(LongTail);
          long_done = 1'b1;
        end else begin
          build_buffer(0);
        end
        foreach (buffer_q[i]) begin
          send_octet(buffer_q[i], i == buffer_q.size() - 1);
          n = parse_octet(buffer_q[i], i == buffer_q.size() - 1, r0, r1);
          if (n > 0) telegram_results_q.push_back(r0);
          if (n > 1) telegram_results_q.push_back(r1);
          items_sent++;
        end
        if ($urandom_range(99) < 3) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (telegram_results_q.size() != 0) begin
      $error("%0d results never arrived", telegram_results_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** fdl_telegram_parser_core: PASSED **");
    end else begin
      $display("** fdl_telegram_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
